// ===== design/gb5_pkg.sv =====
// ----------------------------------------------------------------------------
// gb5_pkg
// Types and constants shared by the 5x5 Gaussian blur: the word formats,
// register map, weight classes and arithmetic widths.
// ----------------------------------------------------------------------------
package gb5_pkg;

	localparam int PIX_W       = 8;
	localparam int POS_W       = 11;
	localparam int GEOM_W      = 12;
	localparam int COEF_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;

	localparam int KERNEL_SIZE = 5;
	localparam int LINES       = KERNEL_SIZE - 1;
	localparam int SLOT_W      = 2;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE_FAR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_AXIS_FAR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_DIAG_NEAR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_AXIS_NEAR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER    = 3'd7;

	// weight classes, ordered as their registers
	localparam int NUM_CLS       = 6;
	localparam int CLS_CORNER    = 0;
	localparam int CLS_EDGE_FAR  = 1;
	localparam int CLS_AXIS_FAR  = 2;
	localparam int CLS_DIAG_NEAR = 3;
	localparam int CLS_AXIS_NEAR = 4;
	localparam int CLS_CENTER    = 5;

	localparam logic [GEOM_W-1:0] LINE_WIDTH_RESET   = 12'd2048;
	localparam logic [GEOM_W-1:0] FRAME_HEIGHT_RESET = 12'd2048;
	localparam logic [COEF_W-1:0] COEF_RESET [NUM_CLS] = '{
		16'd214, 16'd934, 16'd1448, 16'd4080, 16'd6324, 16'd9802
	};

	// a class sums at most eight pixels
	localparam int CSUM_W = PIX_W + 3;
	localparam int PROD_W = COEF_W + CSUM_W;
	localparam int SUM_W  = COEF_W + PIX_W + 5;
	localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (COEF_W - 1);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic [POS_W-1:0] out_col;
		logic [POS_W-1:0] out_row;
		logic             frame_end;
	} result_t;

endpackage

// ===== design/gaussian_blur_5x5.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_5x5
// Streaming 5x5 Gaussian filter for 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one filtered word per clock for every
// interior pixel while neither side stalls; the two-pixel border gives no word.
// A result passes the registered stages in order: line-store read, window and
// class sums, six multipliers, two partial sums, final add and saturate.
// The rate is set by the four line-store RAMs of MAX_WIDTH bytes each, which
// are all read and one written per pixel taken at the current column. Stages hold
// under backpressure and bubbles close up. The line stores are not cleared at
// reset; start each frame with frame_start and keep the geometry constant
// within a frame. Geometry and weights may only be written while idle.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5 #(
	parameter int MAX_WIDTH  = gb5_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = gb5_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	output logic                           pixel_ready,
	input  gb5_pkg::pixel_t                pixel,
	output logic                           result_valid,
	input  logic                           result_ready,
	output gb5_pkg::result_t               result,
	input  logic                           cfg_write,
	input  logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gb5_pkg::CFG_W-1:0]      cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT);
	localparam int WCW  = (gb5_pkg::GEOM_W > AW + 1) ? gb5_pkg::GEOM_W : AW + 1;
	localparam int HCW  = (gb5_pkg::GEOM_W > HW + 1) ? gb5_pkg::GEOM_W : HW + 1;
	localparam int CXW  = (AW > gb5_pkg::POS_W) ? AW : gb5_pkg::POS_W;
	localparam int RXW  = (HW > gb5_pkg::POS_W) ? HW : gb5_pkg::POS_W;
	localparam int KS   = gb5_pkg::KERNEL_SIZE;
	localparam int PW   = gb5_pkg::PIX_W;

	typedef struct packed {
		logic [gb5_pkg::POS_W-1:0] ocol;
		logic [gb5_pkg::POS_W-1:0] orow;
		logic                      fend;
	} meta_t;

	// configuration
	logic [gb5_pkg::GEOM_W-1:0] line_width_q;
	logic [gb5_pkg::GEOM_W-1:0] frame_height_q;
	logic [gb5_pkg::COEF_W-1:0] coef_q [gb5_pkg::NUM_CLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= gb5_pkg::LINE_WIDTH_RESET;
			frame_height_q <= gb5_pkg::FRAME_HEIGHT_RESET;
			for (int i = 0; i < gb5_pkg::NUM_CLS; i++) begin
				coef_q[i] <= gb5_pkg::COEF_RESET[i];
			end
		end else if (cfg_write) begin
			unique case (cfg_index)
				gb5_pkg::REG_LINE_WIDTH: begin
					line_width_q <= cfg_data[gb5_pkg::GEOM_W-1:0];
				end
				gb5_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[gb5_pkg::GEOM_W-1:0];
				end
				gb5_pkg::REG_COEF_CORNER: begin
					coef_q[gb5_pkg::CLS_CORNER] <= cfg_data;
				end
				gb5_pkg::REG_COEF_EDGE_FAR: begin
					coef_q[gb5_pkg::CLS_EDGE_FAR] <= cfg_data;
				end
				gb5_pkg::REG_COEF_AXIS_FAR: begin
					coef_q[gb5_pkg::CLS_AXIS_FAR] <= cfg_data;
				end
				gb5_pkg::REG_COEF_DIAG_NEAR: begin
					coef_q[gb5_pkg::CLS_DIAG_NEAR] <= cfg_data;
				end
				gb5_pkg::REG_COEF_AXIS_NEAR: begin
					coef_q[gb5_pkg::CLS_AXIS_NEAR] <= cfg_data;
				end
				gb5_pkg::REG_COEF_CENTER: begin
					coef_q[gb5_pkg::CLS_CENTER] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, result_valid_q;
	logic emit_s1;
	logic out_free, s4_free, s3_free, s2_free;
	logic s4_go, s3_go, s2_go, s1_go, accept;

	always_comb begin
		out_free    = !result_valid_q || result_ready;
		s4_go       = v_s4 && out_free;
		s4_free     = !v_s4 || out_free;
		s3_go       = v_s3 && s4_free;
		s3_free     = !v_s3 || s4_free;
		s2_go       = v_s2 && s3_free;
		s2_free     = !v_s2 || s3_free;
		s1_go       = v_s1 && (!emit_s1 || s2_free);
		pixel_ready = !v_s1 || s1_go;
		accept      = pixel_valid && pixel_ready;
	end

	// position tracking
	logic [AW-1:0]   col_q;
	logic [HW-1:0]   row_q;
	logic [AW:0]     w_eff;
	logic [HW:0]     h_eff;
	logic [AW-1:0]   col;
	logic [HW-1:0]   row;
	logic [AW:0]     col_inc;
	logic [HW:0]     row_inc;
	logic [AW-1:0]   col_nx;
	logic [HW-1:0]   row_nx;
	logic            emit;
	logic            fend;
	logic [CXW-1:0]  colx;
	logic [RXW-1:0]  rowx;
	logic [gb5_pkg::POS_W-1:0] ocol, orow;

	always_comb begin
		logic [WCW-1:0] lw;
		logic [HCW-1:0] fh;
		lw = WCW'(line_width_q);
		fh = HCW'(frame_height_q);
		if (lw > WCW'(MAX_WIDTH)) lw = WCW'(MAX_WIDTH);
		if (lw == '0) lw = WCW'(1);
		if (fh > HCW'(MAX_HEIGHT)) fh = HCW'(MAX_HEIGHT);
		if (fh == '0) fh = HCW'(1);
		w_eff = (AW+1)'(lw);
		h_eff = (HW+1)'(fh);

		col = col_q;
		row = row_q;
		if (pixel.frame_start) begin
			col = '0;
			row = '0;
		end
		if ({1'b0, col} >= w_eff) col = '0;
		if ({1'b0, row} >= h_eff) row = '0;

		col_inc = {1'b0, col} + (AW+1)'(1);
		row_inc = {1'b0, row} + (HW+1)'(1);
		col_nx  = col_inc[AW-1:0];
		row_nx  = row;
		if (col_inc >= w_eff) begin
			col_nx = '0;
			row_nx = row_inc[HW-1:0];
			if (row_inc >= h_eff) row_nx = '0;
		end

		emit = ({1'b0, row} >= (HW+1)'(gb5_pkg::LINES))
			&& ({1'b0, col} >= (AW+1)'(gb5_pkg::LINES));
		fend = ({1'b0, row} == h_eff - (HW+1)'(1))
			&& ({1'b0, col} == w_eff - (AW+1)'(1));
		colx = CXW'(col) - CXW'(2);
		rowx = RXW'(row) - RXW'(2);
		ocol = colx[gb5_pkg::POS_W-1:0];
		orow = rowx[gb5_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	// line stores: slot (row mod 4) takes the new pixel, all four are read
	logic [PW-1:0] rd_s1 [gb5_pkg::LINES];
	logic [gb5_pkg::SLOT_W-1:0] wslot;
	assign wslot = row[gb5_pkg::SLOT_W-1:0];

	for (genvar p = 0; p < gb5_pkg::LINES; p++) begin : g_line
		logic [PW-1:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (accept) begin
				rd_s1[p] <= mem[col];
				if (wslot == gb5_pkg::SLOT_W'(p)) begin
					mem[col] <= pixel.pixel_in;
				end
			end
		end
	end

	// stage 1
	logic [PW-1:0]              px_s1;
	logic [gb5_pkg::SLOT_W-1:0] slot_s1;
	meta_t                      meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixel_ready) begin
			v_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel.pixel_in;
			slot_s1 <= wslot;
			emit_s1 <= emit;
			meta_s1 <= '{ocol: ocol, orow: orow, fend: fend};
		end
	end

	// window shift and class sums
	logic [PW-1:0] win_q  [KS][KS];
	logic [PW-1:0] win_nx [KS][KS];
	logic [PW-1:0] column [KS];
	logic [gb5_pkg::CSUM_W-1:0] csum [gb5_pkg::NUM_CLS];

	always_comb begin
		// rows row-4 .. row-1 sit in slots (row+k) mod 4
		for (int k = 0; k < gb5_pkg::LINES; k++) begin
			column[k] = rd_s1[slot_s1 + gb5_pkg::SLOT_W'(k)];
		end
		column[KS-1] = px_s1;
		for (int r = 0; r < KS; r++) begin
			for (int c = 0; c < KS - 1; c++) begin
				win_nx[r][c] = win_q[r][c+1];
			end
			win_nx[r][KS-1] = column[r];
		end
	end

	function automatic logic [gb5_pkg::CSUM_W-1:0] ext(input logic [PW-1:0] v);
		return gb5_pkg::CSUM_W'(v);
	endfunction

	always_comb begin
		csum[gb5_pkg::CLS_CORNER] = ext(win_nx[0][0]) + ext(win_nx[0][4])
			+ ext(win_nx[4][0]) + ext(win_nx[4][4]);
		csum[gb5_pkg::CLS_EDGE_FAR] = ext(win_nx[0][1]) + ext(win_nx[0][3])
			+ ext(win_nx[4][1]) + ext(win_nx[4][3])
			+ ext(win_nx[1][0]) + ext(win_nx[3][0])
			+ ext(win_nx[1][4]) + ext(win_nx[3][4]);
		csum[gb5_pkg::CLS_AXIS_FAR] = ext(win_nx[0][2]) + ext(win_nx[4][2])
			+ ext(win_nx[2][0]) + ext(win_nx[2][4]);
		csum[gb5_pkg::CLS_DIAG_NEAR] = ext(win_nx[1][1]) + ext(win_nx[1][3])
			+ ext(win_nx[3][1]) + ext(win_nx[3][3]);
		csum[gb5_pkg::CLS_AXIS_NEAR] = ext(win_nx[1][2]) + ext(win_nx[3][2])
			+ ext(win_nx[2][1]) + ext(win_nx[2][3]);
		csum[gb5_pkg::CLS_CENTER] = ext(win_nx[2][2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KS; r++) begin
				for (int c = 0; c < KS; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (s1_go) begin
			win_q <= win_nx;
		end
	end

	// stage 2: class sums
	logic [gb5_pkg::CSUM_W-1:0] csum_s2 [gb5_pkg::NUM_CLS];
	meta_t                      meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_go && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit_s1 && s2_free) begin
			csum_s2 <= csum;
			meta_s2 <= meta_s1;
		end
	end

	// stage 3: one product per class
	logic [gb5_pkg::PROD_W-1:0] prod_s3 [gb5_pkg::NUM_CLS];
	meta_t                      meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			for (int i = 0; i < gb5_pkg::NUM_CLS; i++) begin
				prod_s3[i] <= gb5_pkg::PROD_W'(coef_q[i]) * gb5_pkg::PROD_W'(csum_s2[i]);
			end
			meta_s3 <= meta_s2;
		end
	end

	// stage 4: two partial sums, rounding folded into the first
	logic [gb5_pkg::SUM_W-1:0] psa_s4, psb_s4;
	meta_t                     meta_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (s4_free) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			psa_s4 <= gb5_pkg::SUM_W'(prod_s3[0]) + gb5_pkg::SUM_W'(prod_s3[1])
				+ gb5_pkg::SUM_W'(prod_s3[2]) + gb5_pkg::ROUND;
			psb_s4 <= gb5_pkg::SUM_W'(prod_s3[3]) + gb5_pkg::SUM_W'(prod_s3[4])
				+ gb5_pkg::SUM_W'(prod_s3[5]);
			meta_s4 <= meta_s3;
		end
	end

	// output word
	logic [gb5_pkg::SUM_W-1:0]        total;
	logic [gb5_pkg::SUM_W-gb5_pkg::COEF_W-1:0] scaled;
	logic [PW-1:0]                    sat;
	gb5_pkg::result_t                 result_q;

	always_comb begin
		total  = psa_s4 + psb_s4;
		scaled = total[gb5_pkg::SUM_W-1:gb5_pkg::COEF_W];
		if (|scaled[gb5_pkg::SUM_W-gb5_pkg::COEF_W-1:PW]) begin
			sat = '1;
		end else begin
			sat = scaled[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_go) begin
			result_q.pixel_out <= sat;
			result_q.out_col   <= meta_s4.ocol;
			result_q.out_row   <= meta_s4.orow;
			result_q.frame_end <= meta_s4.fend;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== test/tb_gaussian_blur_5x5.sv =====
// ----------------------------------------------------------------------------
// tb_gaussian_blur_5x5
// Self-checking testbench for the streaming 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
// Feeds raster-order pixel words through the valid/ready input, predicts each
// filtered word with a local model of the line stores, window and weighted
// sum, and checks every result word in order. Covers reset weights,
// saturation and rounding, tiny geometry, truncated geometry writes,
// mid-frame restarts, and random frames under several sender and receiver
// idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_PCT      = 53;
	localparam int BOTH_IDLE_PCT = 26;
	localparam int RANDOM_ITEMS  = 1130;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          pixel_valid  = 1'b0;
	logic                          pixel_ready;
	gb5_pkg::pixel_t               pixel        = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	gb5_pkg::result_t              result;
	logic                          cfg_write    = 1'b0;
	logic [gb5_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [gb5_pkg::CFG_W-1:0]     cfg_data     = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int error_count    = 0;
	int pixels_sent    = 0;
	int words_checked  = 0;

	// local copy of the block state
	logic [gb5_pkg::GEOM_W-1:0] width_reg;
	logic [gb5_pkg::GEOM_W-1:0] height_reg;
	logic [gb5_pkg::COEF_W-1:0] coef_reg [gb5_pkg::NUM_CLS];
	logic [gb5_pkg::PIX_W-1:0]  line_mem [gb5_pkg::LINES][gb5_pkg::DEF_MAX_WIDTH];
	logic [gb5_pkg::PIX_W-1:0]  win [gb5_pkg::KERNEL_SIZE][gb5_pkg::KERNEL_SIZE];
	int unsigned                col_pos;
	int unsigned                row_pos;

	gb5_pkg::result_t blurred_queue [$];

	gaussian_blur_5x5 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[gaussian_blur_5x5] ERROR");
			$finish;
		end
	end

	// result side: check accepted words, then pick next ready
	always @(posedge clk) begin
		gb5_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (blurred_queue.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word, expected none, got %0d/%0d/%0d/%0b",
					$time, result.pixel_out, result.out_col, result.out_row,
					result.frame_end);
			end else begin
				want = blurred_queue.pop_front();
				words_checked++;
				if (result !== want) begin
					error_count++;
					$display("%0t: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b (pixel/col/row/end)",
						$time, want.pixel_out, want.out_col, want.out_row, want.frame_end,
						result.pixel_out, result.out_col, result.out_row, result.frame_end);
				end
			end
		end
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic int weight_class(input int r, input int c);
		int dy;
		int dx;
		int lo;
		int hi;
		dy = (r < 2) ? 2 - r : r - 2;
		dx = (c < 2) ? 2 - c : c - 2;
		lo = (dy < dx) ? dy : dx;
		hi = (dy < dx) ? dx : dy;
		if (hi == 2)
			return (lo == 2) ? gb5_pkg::CLS_CORNER :
				((lo == 1) ? gb5_pkg::CLS_EDGE_FAR : gb5_pkg::CLS_AXIS_FAR);
		if (hi == 1)
			return (lo == 1) ? gb5_pkg::CLS_DIAG_NEAR : gb5_pkg::CLS_AXIS_NEAR;
		return gb5_pkg::CLS_CENTER;
	endfunction

	function automatic void reset_model();
		width_reg  = gb5_pkg::LINE_WIDTH_RESET;
		height_reg = gb5_pkg::FRAME_HEIGHT_RESET;
		foreach (coef_reg[k]) coef_reg[k] = gb5_pkg::COEF_RESET[k];
		foreach (line_mem[s, x]) line_mem[s][x] = '0;
		foreach (win[r, c]) win[r][c] = '0;
		col_pos = 0;
		row_pos = 0;
	endfunction

	// advance the model by one pixel; returns 1 when a filtered word results
	function automatic bit blur_pixel(input gb5_pkg::pixel_t px,
			output gb5_pkg::result_t res);
		int unsigned               w;
		int unsigned               h;
		int unsigned               col;
		int unsigned               row;
		int unsigned               sum;
		int                        r;
		int                        c;
		bit                        hit;
		logic [gb5_pkg::PIX_W-1:0] column [gb5_pkg::KERNEL_SIZE];
		w = (width_reg > gb5_pkg::DEF_MAX_WIDTH) ? gb5_pkg::DEF_MAX_WIDTH : width_reg;
		h = (height_reg > gb5_pkg::DEF_MAX_HEIGHT) ? gb5_pkg::DEF_MAX_HEIGHT : height_reg;
		if (w == 0) w = 1;
		if (h == 0) h = 1;
		if (px.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		col = col_pos;
		row = row_pos;
		// rows row-4 .. row-1 sit in slots (row+k) mod 4
		for (r = 0; r < gb5_pkg::LINES; r++)
			column[r] = line_mem[(row + r) % gb5_pkg::LINES][col];
		column[gb5_pkg::LINES] = px.pixel_in;
		line_mem[row % gb5_pkg::LINES][col] = px.pixel_in;
		for (r = 0; r < gb5_pkg::KERNEL_SIZE; r++) begin
			for (c = 0; c < gb5_pkg::KERNEL_SIZE - 1; c++)
				win[r][c] = win[r][c + 1];
			win[r][gb5_pkg::KERNEL_SIZE - 1] = column[r];
		end
		hit = 1'b0;
		res = '0;
		if (row >= 4 && col >= 4) begin
			sum = 32'd1 << (gb5_pkg::COEF_W - 1);
			for (r = 0; r < gb5_pkg::KERNEL_SIZE; r++)
				for (c = 0; c < gb5_pkg::KERNEL_SIZE; c++)
					sum += 32'(coef_reg[weight_class(r, c)]) * 32'(win[r][c]);
			sum = sum >> gb5_pkg::COEF_W;
			res.pixel_out = (sum > 255) ? 8'd255 : gb5_pkg::PIX_W'(sum);
			res.out_col   = gb5_pkg::POS_W'(col - 2);
			res.out_row   = gb5_pkg::POS_W'(row - 2);
			res.frame_end = (row == h - 1) && (col == w - 1);
			hit = 1'b1;
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h) row = 0;
		end
		col_pos = col;
		row_pos = row;
		return hit;
	endfunction

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = IDLE_PCT;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = IDLE_PCT;
			end
			default: begin
				send_idle_pct  = BOTH_IDLE_PCT;
				recv_stall_pct = BOTH_IDLE_PCT;
			end
		endcase
	endtask

	task automatic write_reg(input logic [gb5_pkg::CFG_IDX_W-1:0] idx,
			input logic [gb5_pkg::CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			gb5_pkg::REG_LINE_WIDTH:   width_reg = data[gb5_pkg::GEOM_W-1:0];
			gb5_pkg::REG_FRAME_HEIGHT: height_reg = data[gb5_pkg::GEOM_W-1:0];
			default: coef_reg[idx - gb5_pkg::REG_COEF_CORNER] = data[gb5_pkg::COEF_W-1:0];
		endcase
	endtask

	task automatic write_weights(input logic [gb5_pkg::COEF_W-1:0] value);
		int k;
		for (k = 0; k < gb5_pkg::NUM_CLS; k++)
			write_reg(gb5_pkg::CFG_IDX_W'(gb5_pkg::REG_COEF_CORNER + k), value);
	endtask

	task automatic randomize_weights();
		int k;
		int style;
		logic [gb5_pkg::COEF_W-1:0] value;
		style = $urandom_range(3);
		for (k = 0; k < gb5_pkg::NUM_CLS; k++) begin
			case (style)
				0: value = gb5_pkg::COEF_W'($urandom);
				1: value = gb5_pkg::COEF_W'($urandom_range(2047));
				2: value = gb5_pkg::COEF_RESET[k] + gb5_pkg::COEF_W'($urandom_range(255))
					- 16'd128;
				default: value = ($urandom_range(2) == 0) ? 16'd0 :
					(($urandom_range(1) == 0) ? 16'hFFFF : gb5_pkg::COEF_W'($urandom));
			endcase
			write_reg(gb5_pkg::CFG_IDX_W'(gb5_pkg::REG_COEF_CORNER + k), value);
		end
	endtask

	function automatic logic [gb5_pkg::PIX_W-1:0] next_pixel(input int style);
		case (style)
			0: return gb5_pkg::PIX_W'($urandom);
			1: return gb5_pkg::PIX_W'($urandom_range(255, 200));
			2: return gb5_pkg::PIX_W'($urandom_range(31));
			default: return ($urandom_range(3) == 0) ? 8'd0 : 8'd255;
		endcase
	endfunction

	// one word on the pixel channel; valid stays high after acceptance
	task automatic send_pixel(input logic [gb5_pkg::PIX_W-1:0] value, input logic start);
		gb5_pkg::pixel_t  word;
		gb5_pkg::result_t res;
		word.pixel_in    = value;
		word.frame_start = start;
		if ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pixel_valid <= 1'b1;
		pixel       <= word;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		pixels_sent++;
		if (blur_pixel(word, res)) blurred_queue.push_back(res);
	endtask

	// stop sending, wait for every predicted word, then let the pipe empty
	task automatic drain();
		pixel_valid <= 1'b0;
		while (blurred_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input int count, input int style);
		int k;
		for (k = 0; k < count; k++)
			send_pixel(next_pixel(style), k == 0);
	endtask

	// weights stay at reset; a small frame keeps the run short
	task automatic test_reset_defaults();
		set_idle(IDLE_NONE);
		write_reg(gb5_pkg::REG_LINE_WIDTH, 16'd8);
		write_reg(gb5_pkg::REG_FRAME_HEIGHT, 16'd6);
		send_frame(96, 0);
		drain();
	endtask

	task automatic test_saturation();
		int k;
		set_idle(IDLE_RECEIVER);
		write_reg(gb5_pkg::REG_LINE_WIDTH, 16'd5);
		write_reg(gb5_pkg::REG_FRAME_HEIGHT, 16'd5);
		write_weights(16'hFFFF);
		for (k = 0; k < 25; k++)
			send_pixel((k == 3) ? 8'd0 : 8'd255, k == 0);
		drain();
	endtask

	task automatic test_rounding();
		int k;
		set_idle(IDLE_NONE);
		write_weights(16'd0);
		write_reg(gb5_pkg::REG_COEF_CENTER, 16'd32768);
		for (k = 0; k < 25; k++)
			send_pixel(8'd1, k == 0);
		drain();
		write_reg(gb5_pkg::REG_COEF_CENTER, 16'd32767);
		for (k = 0; k < 25; k++)
			send_pixel(8'd1, k == 0);
		drain();
	endtask

	// widths or heights below five leave no interior
	task automatic test_tiny_geometry();
		int k;
		int w [6] = '{0, 1, 4, 8, 8, 4};
		int h [6] = '{8, 8, 8, 0, 4, 4};
		set_idle(IDLE_BOTH);
		randomize_weights();
		for (k = 0; k < 6; k++) begin
			write_reg(gb5_pkg::REG_LINE_WIDTH, gb5_pkg::CFG_W'(w[k]));
			write_reg(gb5_pkg::REG_FRAME_HEIGHT, gb5_pkg::CFG_W'(h[k]));
			send_frame(40, 0);
			drain();
		end
	endtask

	// upper data bits of a geometry write drop
	task automatic test_wide_frame();
		set_idle(IDLE_BOTH);
		write_reg(gb5_pkg::REG_LINE_WIDTH, 16'hF00A);
		write_reg(gb5_pkg::REG_FRAME_HEIGHT, 16'hF006);
		randomize_weights();
		send_frame(60, 0);
		drain();
	endtask

	task automatic test_tall_frame();
		set_idle(IDLE_SENDER);
		write_reg(gb5_pkg::REG_LINE_WIDTH, 16'd5);
		write_reg(gb5_pkg::REG_FRAME_HEIGHT, 16'h8009);
		randomize_weights();
		send_frame(90, 3);
		drain();
	endtask

	// restart mid-frame, then let the next frame follow by wrap alone
	task automatic test_frame_restart();
		int k;
		set_idle(IDLE_NONE);
		write_reg(gb5_pkg::REG_LINE_WIDTH, 16'd9);
		write_reg(gb5_pkg::REG_FRAME_HEIGHT, 16'd7);
		randomize_weights();
		for (k = 0; k < 30; k++)
			send_pixel(next_pixel(0), k == 0);
		for (k = 0; k < 126; k++)
			send_pixel(next_pixel(0), k == 0);
		drain();
	endtask

	task automatic test_random();
		int phase;
		int total;
		int w;
		int h;
		int fsize;
		int npix;
		int k;
		int style;
		int pause_at;
		logic start;
		phase = 0;
		total = 0;
		while (total < RANDOM_ITEMS) begin
			set_idle(idle_mode_t'(phase % 4));
			k = $urandom_range(99);
			w = (k < 80) ? $urandom_range(14, 5) : ((k < 95) ? $urandom_range(48, 15) :
				$urandom_range(4));
			h = ($urandom_range(19) == 0) ? $urandom_range(4) : $urandom_range(10, 5);
			write_reg(gb5_pkg::REG_LINE_WIDTH, gb5_pkg::CFG_W'(w));
			write_reg(gb5_pkg::REG_FRAME_HEIGHT, gb5_pkg::CFG_W'(h));
			randomize_weights();
			fsize = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			npix = fsize * $urandom_range(3, 1);
			if (npix > RANDOM_ITEMS - total) npix = RANDOM_ITEMS - total;
			pause_at = (phase == 1 || $urandom_range(9) == 0) ? $urandom_range(npix - 1) : -1;
			style = 0;
			for (k = 0; k < npix; k++) begin
				if (k == pause_at) drain();
				if (k % fsize == 0) style = $urandom_range(3);
				// mostly clean frames, some wrap-only starts and stray restarts
				start = (k == 0) || ((k % fsize == 0) && ($urandom_range(1) == 0)) ||
					($urandom_range(99) < 2);
				send_pixel(next_pixel(style), start);
			end
			total += npix;
			drain();
			phase++;
		end
	endtask

	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_saturation();
		test_rounding();
		test_tiny_geometry();
		test_wide_frame();
		test_tall_frame();
		test_frame_restart();
		test_random();
		$display("Sent %0d pixel words and checked %0d filtered words over reset weights,",
			pixels_sent, words_checked);
		$display("saturation, rounding, tiny geometry, truncated geometry writes, restarts and random frames.");
		if (error_count == 0) begin
			$display("[gaussian_blur_5x5] OK");
		end else begin
			$display("[gaussian_blur_5x5] ERROR");
		end
		$finish;
	end

endmodule
